### sv/arh_pkg.sv
// Package for the auto-ranging histogram: sizes, payload structs, sequencer states.
// No dependencies; used by every module of the block.
package arh_pkg;
    localparam int SAMPLE_DEPTH = 1024;
    localparam int MAX_BINS     = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int DEFAULT_BINS = 25;
    localparam int ADDR_BITS    = $clog2(SAMPLE_DEPTH);
    localparam int CNT_BITS     = $clog2(SAMPLE_DEPTH + 1);
    localparam int BIN_BITS     = $clog2(MAX_BINS);
    localparam int NB_BITS      = $clog2(MAX_BINS + 1);
    localparam int RANGE_BITS   = SAMPLE_BITS + 1;
    localparam int NUM_BITS     = RANGE_BITS + NB_BITS;
    localparam int PCT_NUM_BITS = CNT_BITS + 15;
    localparam int DIV_BITS     = (NUM_BITS > PCT_NUM_BITS) ? NUM_BITS : PCT_NUM_BITS;
    localparam int DEN_BITS     = (RANGE_BITS > CNT_BITS) ? RANGE_BITS : CNT_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic [5:0]                    bin_index;
        logic signed [SAMPLE_BITS-1:0] bin_low_edge;
        logic [10:0]                   bin_total;
        logic [14:0]                   percent_q8;
        logic                          last_bin;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_RD, S_DIVB, S_WAITB, S_ACC, S_INC,
        S_EDGE, S_WAITE, S_PCT, S_WAITP, S_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } t_div_req;
endpackage

### sv/arh_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on arh_pkg.
module arh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arh_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [arh_pkg::DIV_BITS-1:0]  o_quot
);
    localparam int W = arh_pkg::DIV_BITS;
    localparam int D = arh_pkg::DEN_BITS;
    localparam int SB = $clog2(W + 1);

    logic [W-1:0] r_q, n_q;
    logic [D:0]   r_rem, n_rem;
    logic [D-1:0] r_den;
    logic [SB-1:0] r_cnt;
    logic         r_busy;
    logic [D:0]   w_try;

    always_comb begin
        w_try = {r_rem[D-1:0], r_q[W-1]};
        n_q   = {r_q[W-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= SB'(W);
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SB'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

### sv/auto_range_histogram.sv
// Auto-ranging histogram: accepts one sample per cycle while loading and stores up to
// SAMPLE_DEPTH of them. From the flagged item it clears the bin counters, bins each held
// sample, then computes and shows one bin item at a time, each after the last is taken,
// all through one shared serial divider (DIV_BITS = 26 quotient bits per division).
// Input is not ready from the flagged item until the last bin item is taken.
// Reset (synchronous, active low) sets min/max/count to their start values and the bin setting to 0 (N = DEFAULT_BINS).
module auto_range_histogram (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  arh_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output arh_pkg::t_out_item   o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int SB = arh_pkg::SAMPLE_BITS;
    localparam int AB = arh_pkg::ADDR_BITS;
    localparam int CB = arh_pkg::CNT_BITS;
    localparam int BB = arh_pkg::BIN_BITS;
    localparam int NB = arh_pkg::NB_BITS;
    localparam int RB = arh_pkg::RANGE_BITS;
    localparam int DW = arh_pkg::DIV_BITS;
    localparam int DN = arh_pkg::DEN_BITS;

    arh_pkg::t_state r_state, n_state;
    logic [6:0] r_setting;
    logic signed [SB-1:0] r_min, r_max;
    logic [CB-1:0] r_held, r_k;
    logic [BB:0]   r_bin;
    logic [10:0]   r_cnt [arh_pkg::MAX_BINS];
    logic [SB-1:0] r_mem [arh_pkg::SAMPLE_DEPTH];
    logic [SB-1:0] r_rd;
    logic [10:0]   r_total;
    logic [10:0]   r_cval;
    logic [BB-1:0] r_widx;
    logic signed [SB-1:0] r_edge;
    logic [RB-1:0] w_range;
    logic [NB-1:0] w_n;
    logic [RB-1:0] w_diff;
    logic          w_acc, w_bin_zero;
    arh_pkg::t_div_req w_req;
    logic          w_done;
    logic [DW-1:0] w_quot;
    logic [BB-1:0] w_b;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_setting};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_setting <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_setting <= pwdata[6:0];
    end

    always_comb begin
        if (r_setting == 7'd0) w_n = NB'(arh_pkg::DEFAULT_BINS);
        else if (r_setting > 7'(arh_pkg::MAX_BINS)) w_n = NB'(arh_pkg::MAX_BINS);
        else w_n = NB'(r_setting);
        if (arh_pkg::DEFAULT_BINS > arh_pkg::MAX_BINS && r_setting == 7'd0)
            w_n = NB'(arh_pkg::MAX_BINS);
    end

    assign w_range = (r_max > r_min) ? RB'($signed({r_max[SB-1], r_max}) -
                     $signed({r_min[SB-1], r_min})) : '0;
    assign w_diff  = RB'($signed({r_rd[SB-1], r_rd}) - $signed({r_min[SB-1], r_min}));
    assign w_bin_zero = (w_range == '0) || ($signed(r_rd) <= r_min);
    assign w_acc = o_ready && i_valid && (r_held < CB'(arh_pkg::SAMPLE_DEPTH));
    assign o_ready = (r_state == arh_pkg::S_LOAD);

    always_comb begin
        w_req = '0;
        unique case (r_state)
            arh_pkg::S_DIVB: begin
                w_req.start = 1'b1;
                w_req.num = DW'(w_diff * w_n);
                w_req.den = DN'(w_range);
            end
            arh_pkg::S_EDGE: begin
                w_req.start = 1'b1;
                w_req.num = DW'(w_range * r_bin[BB-1:0]);
                w_req.den = DN'(w_n);
            end
            arh_pkg::S_PCT: begin
                w_req.start = 1'b1;
                w_req.num = DW'(r_total * 15'd25600);
                w_req.den = DN'(r_held);
            end
            default: w_req = '0;
        endcase
    end

    arh_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                   .o_done(w_done), .o_quot(w_quot));

    assign w_b = w_bin_zero ? '0 :
                 ((w_quot >= DW'(w_n)) ? BB'(w_n - 1'b1) : BB'(w_quot));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arh_pkg::S_LOAD:  if (i_valid && i_data.last_sample) n_state = arh_pkg::S_CLEAR;
            arh_pkg::S_CLEAR: if (r_bin == (BB+1)'(arh_pkg::MAX_BINS - 1))
                                  n_state = (r_held == '0) ? arh_pkg::S_EDGE : arh_pkg::S_RD;
            arh_pkg::S_RD:    n_state = arh_pkg::S_DIVB;
            arh_pkg::S_DIVB:  n_state = arh_pkg::S_WAITB;
            arh_pkg::S_WAITB: if (w_done) n_state = arh_pkg::S_ACC;
            arh_pkg::S_ACC:   n_state = arh_pkg::S_INC;
            arh_pkg::S_INC:   n_state = ((r_k + 1'b1) == r_held) ? arh_pkg::S_EDGE
                                                                 : arh_pkg::S_RD;
            arh_pkg::S_EDGE:  n_state = arh_pkg::S_WAITE;
            arh_pkg::S_WAITE: if (w_done) n_state = arh_pkg::S_PCT;
            arh_pkg::S_PCT:   n_state = (r_held == '0) ? arh_pkg::S_OUT : arh_pkg::S_WAITP;
            arh_pkg::S_WAITP: if (w_done) n_state = arh_pkg::S_OUT;
            arh_pkg::S_OUT:   if (i_ready)
                                  n_state = (NB'(r_bin) + 1'b1 == w_n) ? arh_pkg::S_LOAD
                                                                       : arh_pkg::S_EDGE;
            default:          n_state = arh_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_mem[r_held[AB-1:0]] <= i_data.sample;
        r_rd <= r_mem[r_k[AB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arh_pkg::S_LOAD;
            r_min   <= {1'b0, {(SB-1){1'b1}}};
            r_max   <= {1'b1, {(SB-1){1'b0}}};
            r_held  <= '0;
            r_k     <= '0;
            r_bin   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                arh_pkg::S_LOAD: begin
                    if (w_acc) begin
                        r_held <= r_held + 1'b1;
                        if (i_data.sample < r_min) r_min <= i_data.sample;
                        if (i_data.sample > r_max) r_max <= i_data.sample;
                    end
                    r_bin <= '0;
                    r_k   <= '0;
                end
                arh_pkg::S_CLEAR: begin
                    r_cnt[r_bin[BB-1:0]] <= '0;
                    r_bin <= (n_state == arh_pkg::S_CLEAR) ? r_bin + 1'b1 : '0;
                end
                // The counter is read into a register in S_ACC and written back incremented in S_INC.
                arh_pkg::S_ACC: begin
                    r_cval <= r_cnt[w_b];
                    r_widx <= w_b;
                end
                arh_pkg::S_INC: begin
                    r_cnt[r_widx] <= r_cval + 1'b1;
                    r_k <= r_k + 1'b1;
                end
                arh_pkg::S_WAITE: begin
                    r_edge  <= SB'($signed({r_min[SB-1], r_min}) + $signed({1'b0, w_quot[RB-1:0]}));
                    r_total <= r_cnt[r_bin[BB-1:0]];
                end
                arh_pkg::S_PCT: if (r_held == '0) begin
                    o_valid <= 1'b1;
                end
                arh_pkg::S_WAITP: if (w_done) begin
                    o_valid <= 1'b1;
                end
                arh_pkg::S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    r_bin <= r_bin + 1'b1;
                    if (n_state == arh_pkg::S_LOAD) begin
                        r_min  <= {1'b0, {(SB-1){1'b1}}};
                        r_max  <= {1'b1, {(SB-1){1'b0}}};
                        r_held <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == arh_pkg::S_PCT) begin
            o_data.bin_index    <= 6'(r_bin[BB-1:0]);
            o_data.bin_low_edge <= r_edge;
            o_data.bin_total    <= r_total;
            o_data.last_bin     <= (NB'(r_bin) + 1'b1 == w_n);
            if (r_held == '0) o_data.percent_q8 <= '0;
        end
        if (r_state == arh_pkg::S_WAITP && w_done) o_data.percent_q8 <= w_quot[14:0];
    end
endmodule

### sv/arh_checker.sv
// Port-level checker for auto_range_histogram, attached by bind.
// Depends on arh_pkg for the payload types.
module arh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input arh_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input arh_pkg::t_out_item o_data
);
    // A result item is never shown while inputs are being taken.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("result while loading");
    // A flagged item closes the input side.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last_sample |=> !o_ready) else $error("ready after last");
    // Taking the final bin item reopens the input side.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_bin |=> o_ready) else $error("no reopen");
    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data)) else $error("payload moved");
endmodule

bind auto_range_histogram arh_checker u_arh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
